// ===== rtl/isotp_segmenting_sender_macros.svh =====
// Assertion macros for the ISO-TP sender.
`ifndef ISOTP_SEGMENTING_SENDER_MACROS_SVH
`define ISOTP_SEGMENTING_SENDER_MACROS_SVH
// Implication checked on every clock, disabled in reset.
`define ISTP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked on every clock, disabled in reset.
`define ISTP_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/istp_pkg.sv =====
// ----------------------------------------------------------------------------
// ISO-TP sender package
// Shared constants, state codes and types of the segmenting sender.
// ----------------------------------------------------------------------------
package istp_pkg;
    localparam int unsigned MAX_MSG   = 4095;
    localparam int unsigned BUF_DEPTH = 4096;
    localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_START = 2'd1;
    localparam logic [1:0] K_FLOW  = 2'd2;
    localparam logic [1:0] K_TICK  = 2'd3;

    localparam logic [1:0] CFG_FRAME_LEN = 2'd0;
    localparam logic [1:0] CFG_AS_TO     = 2'd1;
    localparam logic [1:0] CFG_BS_TO     = 2'd2;

    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_DONE  = 3'd1;
    localparam logic [2:0] EV_BS    = 3'd2;
    localparam logic [2:0] EV_AS    = 3'd3;
    localparam logic [2:0] EV_UNEXP = 3'd4;
    localparam logic [2:0] EV_OVF   = 3'd5;
    localparam logic [2:0] EV_INV   = 3'd6;

    localparam logic [7:0] FS_CTS  = 8'd0;
    localparam logic [7:0] FS_WAIT = 8'd1;
    localparam logic [7:0] FS_OVF  = 8'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_SEND  = 2'd2,
        PH_PAUSE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_READY = 2'd0,
        S_EMIT  = 2'd1,
        S_LAST  = 2'd2
    } t_seq;

    // One frame to stream: header bytes then buffer bytes.
    typedef struct packed {
        logic [1:0]        n_hdr;
        logic [7:0]        hdr0;
        logic [7:0]        hdr1;
        logic [BUF_AW-1:0] base;
        logic [6:0]        n_data;
        logic [1:0]        st;
        logic [2:0]        ev;
        logic              report;
    } t_frame;
endpackage

// ===== rtl/istp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module istp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/isotp_segmenting_sender.sv =====
// A load or silent item gives no result; a frame item is registered into the emit state
// and its results leave through the output registers, one result per cycle.
// A new item is not taken while a frame streams: busy holds until it ends, set by the
// single buffer read port streaming one byte per cycle.
// Reset is synchronous active low; the buffer contents are undefined until loaded.
// The receiver cannot stall: each result is shown for one cycle with o_strobe.
module isotp_segmenting_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_byte_index,
    input  logic [11:0] i_msg_length,
    input  logic [7:0]  i_block_size,
    input  logic [7:0]  i_sep_time,
    input  logic        i_link_ready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_has_byte,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    output logic [1:0]  o_send_status,
    output logic [2:0]  o_event_code
);
    localparam int unsigned AW = istp_pkg::BUF_AW;

    istp_pkg::t_phase r_phase, n_phase;
    istp_pkg::t_seq   r_seq, n_seq;
    logic [11:0] r_msg_size, n_msg_size, r_sent, n_sent;
    logic [3:0]  r_sn, n_sn;
    logic [7:0]  r_bc, n_bc, r_bl, n_bl;
    logic [6:0]  r_gap, n_gap, r_gc, n_gc;
    logic [15:0] r_bs, n_bs, r_as, n_as;
    logic        r_bs_run, n_bs_run, r_as_run, n_as_run;
    logic [6:0]  r_flen;
    logic [15:0] r_as_to, r_bs_to;
    istp_pkg::t_frame r_fr, n_fr;
    logic [6:0]  r_cnt, n_cnt;
    logic [AW-1:0] r_raddr, n_raddr;
    logic        r_out_v, n_out_v, r_out_hb, n_out_hb, r_out_end, n_out_end;
    logic [7:0]  r_out_b, n_out_b;
    logic        r_out_fromram, n_out_fromram;
    logic [7:0]  w_rdata;
    logic        w_acc;
    logic [6:0]  w_fl;
    logic [11:0] w_rem, w_cpy;

    assign w_acc       = start && !busy;
    assign busy        = (r_seq != istp_pkg::S_READY);
    assign o_cfg_ready = 1'b1;
    assign w_fl = (r_flen < 7'd8) ? 7'd8 : ((r_flen > 7'd64) ? 7'd64 : r_flen);

    istp_ram #(.WIDTH(8), .DEPTH(istp_pkg::BUF_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_acc && i_kind == istp_pkg::K_LOAD),
        .i_waddr (i_byte_index[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (r_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flen  <= 7'd8;
            r_as_to <= 16'd1000;
            r_bs_to <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                istp_pkg::CFG_FRAME_LEN: r_flen  <= i_cfg_data[6:0];
                istp_pkg::CFG_AS_TO:     r_as_to <= i_cfg_data;
                istp_pkg::CFG_BS_TO:     r_bs_to <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= istp_pkg::PH_IDLE; r_seq <= istp_pkg::S_READY;
            r_msg_size <= '0; r_sent <= '0; r_sn <= '0; r_bc <= '0; r_bl <= '0;
            r_gap <= '0; r_gc <= '0; r_bs <= '0; r_as <= '0;
            r_bs_run <= 1'b0; r_as_run <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_phase <= n_phase; r_seq <= n_seq;
            r_msg_size <= n_msg_size; r_sent <= n_sent; r_sn <= n_sn;
            r_bc <= n_bc; r_bl <= n_bl; r_gap <= n_gap; r_gc <= n_gc;
            r_bs <= n_bs; r_as <= n_as; r_bs_run <= n_bs_run; r_as_run <= n_as_run;
            r_out_v <= n_out_v;
        end
        r_fr <= n_fr; r_cnt <= n_cnt; r_raddr <= n_raddr;
        r_out_hb <= n_out_hb; r_out_end <= n_out_end; r_out_b <= n_out_b;
        r_out_fromram <= n_out_fromram;
    end

    assign o_strobe      = r_out_v;
    assign o_has_byte    = r_out_v && r_out_hb;
    assign o_frame_byte  = (r_out_v && r_out_hb) ? (r_out_fromram ? w_rdata : r_out_b) : 8'd0;
    assign o_frame_end   = r_out_v && r_out_end;
    assign o_send_status = r_out_v ? r_fr.st : istp_pkg::ST_NONE;
    assign o_event_code  = r_out_v ? r_fr.ev : istp_pkg::EV_NONE;

    always_comb begin
        logic [7:0] v_fs;
        logic [6:0] v_gc;
        logic       v_cf, v_done;
        logic [15:0] v_bs, v_as;
        logic [7:0]  v_bc;
        logic [6:0]  v_total;
        v_fs = i_data_byte; v_gc = r_gc; v_cf = 1'b0; v_done = 1'b0;
        v_bs = r_bs; v_as = r_as; v_bc = r_bc; v_total = '0;
        n_phase = r_phase; n_seq = r_seq; n_msg_size = r_msg_size; n_sent = r_sent;
        n_sn = r_sn; n_bc = r_bc; n_bl = r_bl; n_gap = r_gap; n_gc = r_gc;
        n_bs = r_bs; n_as = r_as; n_bs_run = r_bs_run; n_as_run = r_as_run;
        n_fr = r_fr; n_cnt = r_cnt; n_raddr = r_raddr;
        n_out_v = 1'b0; n_out_hb = 1'b0; n_out_end = 1'b0; n_out_b = 8'd0;
        n_out_fromram = 1'b0;
        w_rem = (r_sent < r_msg_size) ? r_msg_size - r_sent : 12'd0;
        w_cpy = (w_rem < {5'd0, w_fl - 7'd1}) ? w_rem : {5'd0, w_fl - 7'd1};
        case (r_seq)
            istp_pkg::S_READY: begin
                if (w_acc) begin
                    n_fr = '0;
                    case (i_kind)
                        istp_pkg::K_START: begin
                            n_fr.report = 1'b1;
                            if (i_msg_length == 12'd0) begin
                                n_fr.st = istp_pkg::ST_ZERO;
                            end else begin
                                n_fr.st = istp_pkg::ST_OK;
                                n_phase = istp_pkg::PH_IDLE;
                                n_as_run = 1'b0; n_bs_run = 1'b0;
                                n_msg_size = i_msg_length;
                                if (i_link_ready) begin
                                    if (i_msg_length <= 12'd7) begin
                                        n_fr.n_hdr = 2'd1;
                                        n_fr.hdr0 = i_msg_length[7:0];
                                        n_fr.n_data = i_msg_length[6:0];
                                        n_sent = i_msg_length; n_fr.ev = istp_pkg::EV_DONE;
                                    end else if (w_fl > 7'd8 &&
                                            i_msg_length <= {5'd0, w_fl - 7'd2}) begin
                                        n_fr.n_hdr = 2'd2; n_fr.hdr0 = 8'd0;
                                        n_fr.hdr1 = i_msg_length[7:0];
                                        n_fr.n_data = i_msg_length[6:0];
                                        n_sent = i_msg_length; n_fr.ev = istp_pkg::EV_DONE;
                                    end else begin
                                        n_fr.n_hdr = 2'd2;
                                        n_fr.hdr0 = {4'h1, i_msg_length[11:8]};
                                        n_fr.hdr1 = i_msg_length[7:0];
                                        n_fr.n_data = w_fl - 7'd2;
                                        n_sent = {5'd0, w_fl - 7'd2};
                                        n_sn = 4'd0; n_phase = istp_pkg::PH_WAIT;
                                        n_bs_run = 1'b1; n_bs = 16'd0;
                                    end
                                end
                            end
                        end
                        istp_pkg::K_FLOW: begin
                            if (r_phase != istp_pkg::PH_WAIT) begin
                                n_phase = istp_pkg::PH_IDLE; n_as_run = 1'b0;
                                n_bs_run = 1'b0; n_fr.ev = istp_pkg::EV_UNEXP;
                                n_fr.report = 1'b1;
                            end else if (v_fs == istp_pkg::FS_CTS) begin
                                n_bs_run = 1'b0; n_bc = 8'd0; n_bl = i_block_size;
                                if (!i_sep_time[7]) n_gap = i_sep_time[6:0];
                                else if (i_sep_time > 8'hF0 && i_sep_time < 8'hFA)
                                    n_gap = 7'd1;
                                else n_gap = 7'h7F;
                                n_gc = 7'd0;
                                n_phase = (n_gap != 7'd0) ? istp_pkg::PH_PAUSE
                                                          : istp_pkg::PH_SEND;
                            end else if (v_fs == istp_pkg::FS_WAIT) begin
                                n_bs_run = 1'b1; n_bs = 16'd0;
                            end else begin
                                n_phase = istp_pkg::PH_IDLE; n_bs_run = 1'b0;
                                n_fr.report = 1'b1;
                                n_fr.ev = (v_fs == istp_pkg::FS_OVF) ? istp_pkg::EV_OVF
                                                                     : istp_pkg::EV_INV;
                            end
                        end
                        istp_pkg::K_TICK: begin
                            if (r_bs_run && r_bs != 16'hFFFF) v_bs = r_bs + 16'd1;
                            if (r_as_run && r_as != 16'hFFFF) v_as = r_as + 16'd1;
                            n_bs = v_bs; n_as = v_as;
                            case (r_phase)
                                istp_pkg::PH_WAIT: begin
                                    if (r_bs_run && v_bs >= r_bs_to) begin
                                        n_phase = istp_pkg::PH_IDLE; n_bs_run = 1'b0;
                                        n_fr.ev = istp_pkg::EV_BS; n_fr.report = 1'b1;
                                    end
                                end
                                istp_pkg::PH_PAUSE: begin
                                    if (r_gc != 7'h7F) v_gc = r_gc + 7'd1;
                                    n_gc = v_gc;
                                    if (v_gc >= r_gap) begin
                                        n_phase = istp_pkg::PH_SEND; v_cf = 1'b1;
                                    end
                                end
                                istp_pkg::PH_SEND: v_cf = 1'b1;
                                default: ;
                            endcase
                            if (v_cf) begin
                                if (!r_as_run) begin
                                    n_as_run = 1'b1; v_as = 16'd0; n_as = 16'd0;
                                end
                                if (i_link_ready) begin
                                    n_as_run = 1'b0;
                                    n_sn = r_sn + 4'd1;
                                    n_fr.n_hdr = 2'd1; n_fr.hdr0 = {4'h2, r_sn + 4'd1};
                                    n_fr.base = r_sent[AW-1:0];
                                    n_fr.n_data = w_cpy[6:0];
                                    n_sent = r_sent + w_cpy;
                                    v_done = (n_sent >= r_msg_size);
                                    if (v_done) begin
                                        n_phase = istp_pkg::PH_IDLE;
                                        n_fr.ev = istp_pkg::EV_DONE;
                                    end else begin
                                        v_bc = r_bc + 8'd1;
                                        if (r_bl != 8'd0) n_bc = v_bc;
                                        if (r_bl != 8'd0 && v_bc >= r_bl) begin
                                            n_phase = istp_pkg::PH_WAIT;
                                            n_bs_run = 1'b1; n_bs = 16'd0;
                                        end else if (r_gap != 7'd0) begin
                                            n_phase = istp_pkg::PH_PAUSE; n_gc = 7'd0;
                                        end
                                    end
                                end else if (v_as >= r_as_to) begin
                                    n_phase = istp_pkg::PH_IDLE; n_as_run = 1'b0;
                                    n_fr.ev = istp_pkg::EV_AS; n_fr.report = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    v_total = {5'd0, n_fr.n_hdr} + n_fr.n_data;
                    if (v_total != 7'd0 || n_fr.report) begin
                        n_seq = istp_pkg::S_EMIT;
                        n_cnt = 7'd0;
                    end
                    n_raddr = n_fr.base;
                end
            end
            istp_pkg::S_EMIT: begin
                v_total = {5'd0, r_fr.n_hdr} + r_fr.n_data;
                n_out_v = 1'b1;
                n_out_hb = (v_total != 7'd0);
                n_out_end = (r_cnt + 7'd1 >= v_total);
                if (r_cnt == 7'd0 && r_fr.n_hdr != 2'd0) n_out_b = r_fr.hdr0;
                else if (r_cnt == 7'd1 && r_fr.n_hdr == 2'd2) n_out_b = r_fr.hdr1;
                else begin
                    n_out_fromram = 1'b1;
                    n_raddr = r_raddr + AW'(1);
                end
                n_cnt = r_cnt + 7'd1;
                if (n_out_end) n_seq = istp_pkg::S_LAST;
            end
            istp_pkg::S_LAST: n_seq = istp_pkg::S_READY;
            default: n_seq = istp_pkg::S_READY;
        endcase
    end
endmodule

// ===== rtl/istp_checker.sv =====
// ----------------------------------------------------------------------------
// ISO-TP sender port checker
// Checks result framing against the command handshake.
// ----------------------------------------------------------------------------
`include "isotp_segmenting_sender_macros.svh"
module istp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_has_byte,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_end
);
    `ISTP_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `ISTP_ASSERT_IMP(a_byte_zero, i_clk, i_rst_n, !o_has_byte, o_frame_byte == 8'd0)
    `ISTP_ASSERT_IMP(a_hb_strobe, i_clk, i_rst_n, o_has_byte || o_frame_end, o_strobe)
    `ISTP_ASSERT_NXT(a_end_quiet, i_clk, i_rst_n, o_frame_end, !o_strobe)
endmodule

bind isotp_segmenting_sender istp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_strobe(o_strobe), .o_has_byte(o_has_byte),
    .o_frame_byte(o_frame_byte), .o_frame_end(o_frame_end)
);
